// ----- rtl/dsc_pkg.sv -----
`timescale 1ns / 1ps

package dsc_pkg;

    localparam int MAX_SLICES_DEF = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 17;
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DESAT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WIDE  = 3'd4;

    // item modes
    localparam logic [1:0] MODE_PIXEL  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] in_red;
        logic [15:0] in_green;
        logic [15:0] in_blue;
        logic [15:0] in_alpha;
        logic [15:0] slice_low;
        logic [15:0] slice_high;
        logic [23:0] slice_first_color;
        logic [23:0] slice_last_color;
        logic [16:0] slice_opacity;
    } in_beat_t;

    typedef struct packed {
        logic [15:0] out_red;
        logic [15:0] out_green;
        logic [15:0] out_blue;
        logic [15:0] out_alpha;
        logic        hit;
        logic [4:0]  entries_used;
        logic        status;
    } out_beat_t;

    // one stored slice
    typedef struct packed {
        logic [15:0] lo;
        logic [15:0] hi;
        logic [23:0] first;
        logic [23:0] last;
        logic [16:0] op;
    } slice_t;

    // operand (0..65536) clamp for Q1.16 factors
    function automatic logic [16:0] cap_one(input logic [16:0] v);
        return (v > ONE_Q16) ? ONE_Q16 : v;
    endfunction

    // a*(1-f) + b*f, a and b up to 19 bits, result >> 16
    function automatic logic [20:0] blend(input logic [18:0] a, input logic [18:0] b,
                                          input logic [16:0] f);
        logic [36:0] s;
        s = 37'(a) * 37'(17'(ONE_Q16 - f)) + 37'(b) * 37'(f);
        return s[36:16];
    endfunction

endpackage

// ----- rtl/dsc_div.sv -----
`timescale 1ns / 1ps

// Pipelined restoring divider: 32-bit numerator by 16-bit divisor, one
// quotient bit per step, four steps per register stage.
module dsc_div #(
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              en,
    input  logic [31:0]       num,
    input  logic [15:0]       den,
    input  logic [SIDE_W-1:0] side_in,
    output logic [31:0]       quo,
    output logic [SIDE_W-1:0] side_out
);

    localparam int STEPS = 4;
    localparam int NREG  = 32 / STEPS;

    logic [31:0]       q_reg   [NREG];
    logic [16:0]       r_reg   [NREG];
    logic [15:0]       d_reg   [NREG];
    logic [SIDE_W-1:0] s_reg   [NREG];

    // STEPS quotient bits: returns {quotient/shift word, partial remainder}
    function automatic logic [48:0] div_steps(input logic [31:0] q_in,
                                              input logic [16:0] r_in,
                                              input logic [15:0] d);
        logic [31:0] q;
        logic [16:0] r;
        logic [17:0] t;
        q = q_in;
        r = r_in;
        for (int k = 0; k < STEPS; k++)
        begin
            t = {r, q[31]};
            q = {q[30:0], 1'b0};
            if (t >= 18'(d))
            begin
                t = t - 18'(d);
                q[0] = 1'b1;
            end
            r = t[16:0];
        end
        return {q, r};
    endfunction

    // stage registers
    always_ff @(posedge clk)
    begin
        logic [48:0] st;
        if (en)
        begin
            st = div_steps(num, 17'd0, den);
            q_reg[0] <= st[48:17];
            r_reg[0] <= st[16:0];
            d_reg[0] <= den;
            s_reg[0] <= side_in;
            for (int g = 1; g < NREG; g++)
            begin
                st = div_steps(q_reg[g-1], r_reg[g-1], d_reg[g-1]);
                q_reg[g] <= st[48:17];
                r_reg[g] <= st[16:0];
                d_reg[g] <= d_reg[g-1];
                s_reg[g] <= s_reg[g-1];
            end
        end
    end

    assign quo      = q_reg[NREG-1];
    assign side_out = s_reg[NREG-1];

endmodule

// ----- rtl/dsc_search.sv -----
`timescale 1ns / 1ps

// Slice table in registers with parallel range compare and a
// first-match priority pick.
module dsc_search #(
    parameter int MAX_SLICES = dsc_pkg::MAX_SLICES_DEF,
    parameter int CNT_W      = $clog2(MAX_SLICES + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  dsc_pkg::slice_t      wr_data,
    input  logic                 clr,
    input  logic [18:0]          gray,
    output logic [CNT_W-1:0]     count,
    output logic                 found,
    output dsc_pkg::slice_t      match
);

    dsc_pkg::slice_t        tab_reg [MAX_SLICES];
    logic [CNT_W-1:0]       cnt_reg;
    logic [MAX_SLICES-1:0]  hitv;

    // table write and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (clr)
            cnt_reg <= '0;
        else if (wr_en)
            cnt_reg <= cnt_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && !clr)
            tab_reg[cnt_reg[$clog2(MAX_SLICES > 1 ? MAX_SLICES : 2)-1:0]] <= wr_data;
    end

    // per-entry range test
    always_comb
    begin
        for (int k = 0; k < MAX_SLICES; k++)
            hitv[k] = (CNT_W'(k) < cnt_reg) && (gray >= 19'(tab_reg[k].lo))
                      && (gray <= 19'(tab_reg[k].hi));
    end

    // first match wins
    always_comb
    begin
        found = 1'b0;
        match = tab_reg[0];
        for (int k = MAX_SLICES - 1; k >= 0; k--)
        begin
            if (hitv[k])
            begin
                found = 1'b1;
                match = tab_reg[k];
            end
        end
    end

    assign count = cnt_reg;

endmodule

// ----- rtl/density_slice_colorizer_core.sv -----
`timescale 1ns / 1ps

// Density-slice pseudocolor pipeline. One beat enters per clock when not
// stalled; its result passes the registered stages weighted products, gray
// sum, search, 8 divider stages, fraction and color, blend and output. Table
// items (append, clear) are applied to the slice table at the search stage
// in stream order, so a pixel sees every table change sent ahead of it. The
// whole pipe advances only when the output register is empty or being taken.
module density_slice_colorizer_core #(
    parameter int MAX_SLICES = dsc_pkg::MAX_SLICES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  dsc_pkg::in_beat_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output dsc_pkg::out_beat_t                out_data,
    input  logic                              cfg_we,
    input  logic [dsc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dsc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int CNT_W = $clog2(MAX_SLICES + 1);

    typedef struct packed {
        logic        pix;
        logic        wide;
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
        logic [15:0] a;
        logic [18:0] gray;
        logic        hit;
        logic        status;
        logic [4:0]  used;
        logic [16:0] op;
        logic [16:0] desat;
        logic [23:0] first;
        logic [23:0] last;
    } ctx_t;

    // configuration
    logic [16:0] desat_reg, rw_reg, gw_reg, bw_reg;
    logic        wide_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desat_reg <= '0;
            rw_reg    <= 17'd19595;
            gw_reg    <= 17'd38470;
            bw_reg    <= 17'd7471;
            wide_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dsc_pkg::REG_DESAT: desat_reg <= cfg_wdata;
                dsc_pkg::REG_RW:    rw_reg    <= cfg_wdata;
                dsc_pkg::REG_GW:    gw_reg    <= cfg_wdata;
                dsc_pkg::REG_BW:    bw_reg    <= cfg_wdata;
                dsc_pkg::REG_WIDE:  wide_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    logic en;
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // stage 1: mask samples, weighted products
    logic        v1_reg;
    ctx_t        c1_reg;
    logic [1:0]  m1_reg;
    dsc_pkg::slice_t s1_reg;
    logic [32:0] pr_reg, pg_reg, pb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v1_reg <= 1'b0;
        else if (en) v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        logic [15:0]     mk;
        ctx_t            c1_next;
        dsc_pkg::slice_t s1_next;
        mk = wide_reg ? 16'hFFFF : 16'h00FF;
        c1_next       = '0;
        c1_next.pix   = in_data.mode == dsc_pkg::MODE_PIXEL;
        c1_next.wide  = wide_reg;
        c1_next.r     = in_data.in_red & mk;
        c1_next.g     = in_data.in_green & mk;
        c1_next.b     = in_data.in_blue & mk;
        c1_next.a     = in_data.in_alpha & mk;
        c1_next.desat = dsc_pkg::cap_one(desat_reg);
        s1_next.lo    = in_data.slice_low;
        s1_next.hi    = in_data.slice_high;
        s1_next.first = in_data.slice_first_color;
        s1_next.last  = in_data.slice_last_color;
        s1_next.op    = dsc_pkg::cap_one(in_data.slice_opacity);
        if (en)
        begin
            c1_reg <= c1_next;
            m1_reg <= in_data.mode;
            s1_reg <= s1_next;
            pr_reg <= 33'(in_data.in_red & mk) * 33'(rw_reg);
            pg_reg <= 33'(in_data.in_green & mk) * 33'(gw_reg);
            pb_reg <= 33'(in_data.in_blue & mk) * 33'(bw_reg);
        end
    end

    // stage 2: gray sum, kept at full width
    logic        v2_reg;
    ctx_t        c2_reg;
    logic [1:0]  m2_reg;
    dsc_pkg::slice_t s2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v2_reg <= 1'b0;
        else if (en) v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        logic [34:0] sum;
        ctx_t        c2_next;
        sum = 35'(pr_reg) + 35'(pg_reg) + 35'(pb_reg);
        c2_next      = c1_reg;
        c2_next.gray = sum[34:16];
        if (en)
        begin
            c2_reg <= c2_next;
            m2_reg <= m1_reg;
            s2_reg <= s1_reg;
        end
    end

    // stage 3: table update and search
    logic [CNT_W-1:0] count;
    logic             found;
    dsc_pkg::slice_t  match;
    logic             full, do_app, do_clr;
    logic [CNT_W-1:0] cnt_after;

    assign full   = count >= CNT_W'(MAX_SLICES);
    assign do_app = en && v2_reg && m2_reg == dsc_pkg::MODE_APPEND && !full;
    assign do_clr = en && v2_reg && m2_reg == dsc_pkg::MODE_CLEAR;

    dsc_search #(.MAX_SLICES(MAX_SLICES), .CNT_W(CNT_W)) u_search (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (do_app),
        .wr_data (s2_reg),
        .clr     (do_clr),
        .gray    (c2_reg.gray),
        .count   (count),
        .found   (found),
        .match   (match)
    );

    always_comb
    begin
        if (m2_reg == dsc_pkg::MODE_CLEAR) cnt_after = '0;
        else if (m2_reg == dsc_pkg::MODE_APPEND && !full) cnt_after = count + 1'b1;
        else cnt_after = count;
    end

    ctx_t        c3;
    logic [31:0] num3;
    logic [15:0] den3;

    always_comb
    begin
        logic [15:0] span;
        c3        = c2_reg;
        c3.hit    = c2_reg.pix && found;
        c3.status = m2_reg == dsc_pkg::MODE_APPEND && full;
        c3.used   = 5'(cnt_after);
        c3.op     = match.op;
        c3.first  = match.first;
        c3.last   = match.last;
        span      = match.hi - match.lo;
        den3      = (span == 16'd0) ? 16'd1 : span;
        num3      = {16'(c2_reg.gray - 19'(match.lo)), 16'd0};
    end

    // search result register ahead of the divider
    logic        vq_reg;
    ctx_t        c3_reg;
    logic [31:0] num_reg;
    logic [15:0] den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) vq_reg <= 1'b0;
        else if (en) vq_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c3_reg  <= c3;
            num_reg <= num3;
            den_reg <= den3;
        end
    end

    // divider stages carry the context
    logic        v3_reg;
    logic [31:0] quo;
    ctx_t        c4;
    logic [7:0]  vs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) vs_reg <= '0;
        else if (en) vs_reg <= {vs_reg[6:0], vq_reg};
    end
    assign v3_reg = vs_reg[7];

    dsc_div #(.SIDE_W($bits(ctx_t))) u_div (
        .clk      (clk),
        .en       (en),
        .num      (num_reg),
        .den      (den_reg),
        .side_in  (c3_reg),
        .quo      (quo),
        .side_out (c4)
    );

    // stage: fraction and slice color per channel
    logic        v5_reg;
    ctx_t        c5_reg;
    logic [18:0] col_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v5_reg <= 1'b0;
        else if (en) v5_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        logic [16:0] f;
        logic [20:0] c;
        f = (quo > 32'(dsc_pkg::ONE_Q16)) ? dsc_pkg::ONE_Q16 : quo[16:0];
        if (en)
        begin
            c5_reg <= c4;
            for (int i = 0; i < 3; i++)
            begin
                c = dsc_pkg::blend(19'(c4.first[23-8*i -: 8]),
                                   19'(c4.last[23-8*i -: 8]), f);
                col_reg[i] <= c4.wide ? {c[10:0], 8'd0} : c[18:0];
            end
        end
    end

    // stage: final blend, saturate, zero for table items
    logic        v6_reg;
    ctx_t        c6_reg;
    logic [15:0] res_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v6_reg <= 1'b0;
        else if (en) v6_reg <= v5_reg;
    end

    always_ff @(posedge clk)
    begin
        logic [15:0] px [3];
        logic [20:0] t;
        logic [15:0] top;
        px[0] = c5_reg.r;
        px[1] = c5_reg.g;
        px[2] = c5_reg.b;
        top = c5_reg.wide ? 16'hFFFF : 16'h00FF;
        if (en)
        begin
            c6_reg <= c5_reg;
            for (int i = 0; i < 3; i++)
            begin
                if (c5_reg.hit)
                    t = dsc_pkg::blend(19'(px[i]), col_reg[i], c5_reg.op);
                else
                    t = dsc_pkg::blend(19'(px[i]), c5_reg.gray, c5_reg.desat);
                if (!c5_reg.pix) res_reg[i] <= '0;
                else res_reg[i] <= (t > 21'(top)) ? top : t[15:0];
            end
        end
    end

    // output register
    logic      ov_reg;
    dsc_pkg::out_beat_t od_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) ov_reg <= 1'b0;
        else if (en) ov_reg <= v6_reg;
    end

    always_ff @(posedge clk)
    begin
        dsc_pkg::out_beat_t od_next;
        od_next.out_red      = res_reg[0];
        od_next.out_green    = res_reg[1];
        od_next.out_blue     = res_reg[2];
        od_next.out_alpha    = c6_reg.a;
        od_next.hit          = c6_reg.hit;
        od_next.entries_used = c6_reg.used;
        od_next.status       = c6_reg.status;
        if (en)
            od_reg <= od_next;
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

endmodule
